[hw/rtl/trm_pkg.sv]
// Shared types and constants for the tiny register ALU machine.
// No dependencies; imported by tiny_register_alu_machine.
package trm_pkg;

    localparam int unsigned WordW     = 16;
    localparam int unsigned RegCount  = 8;
    localparam int unsigned RegAddrW  = 3;
    localparam int unsigned FlagW     = 3;
    localparam int unsigned OpW       = 4;
    localparam int unsigned ImmW      = 9;
    localparam int unsigned MDataW    = 40;

    localparam logic [WordW-1:0] PC_RESET = 16'h3000;

    localparam logic [FlagW-1:0] FLAG_POS  = 3'd1;
    localparam logic [FlagW-1:0] FLAG_ZERO = 3'd2;
    localparam logic [FlagW-1:0] FLAG_NEG  = 3'd4;

    typedef enum logic [OpW-1:0] {
        OP_NOP   = 4'd0,
        OP_ADD   = 4'd1,
        OP_LD    = 4'd2,
        OP_AND   = 4'd3,
        OP_NOT   = 4'd4,
        OP_JMP   = 4'd5,
        OP_SHOW  = 4'd6
    } opcode_t;

    function automatic logic [FlagW-1:0] flags_of(input logic [WordW-1:0] v);
        logic [FlagW-1:0] f;
        if (v == '0) begin
            f = FLAG_ZERO;
        end else if (v[WordW-1]) begin
            f = FLAG_NEG;
        end else begin
            f = FLAG_POS;
        end
        return f;
    endfunction

endpackage

[hw/rtl/tiny_register_alu_machine.sv]
// Top level of the tiny register ALU machine: register file memory, execute stage,
// output register. Depends on trm_pkg.
//
// Channel  Dir  Width  Contents
// s_       in   16     tdata: instruction[15:0]
// m_       out  40/1   tdata: print_value, program_counter, condition_flags; tuser: print_valid
//
// One instruction per cycle sustained while m_ does not stall. Both source registers are
// read from the 8x16 register file into registers at acceptance (registered read); the
// execute stage then executes, writes back and loads the output register, which drives m_.
// The last write is forwarded to the next instruction's operands. Reset clears per-entry
// valid bits so the register file reads zero with no clearing pass. A stall on m_ holds the
// execute stage and drops s_tready only when both stages are full.
module tiny_register_alu_machine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [trm_pkg::WordW-1:0]   s_tdata,   // [15:0] instruction
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [trm_pkg::MDataW-1:0]  m_tdata,   // [15:0] print_value, [31:16] program_counter,
                                                   // [34:32] condition_flags, [39:35] zero
    output logic                        m_tuser    // [0] print_valid
);
    import trm_pkg::*;

    // register file
    logic [WordW-1:0]    rf_mem [RegCount];
    logic [RegCount-1:0] rf_valid_reg;
    logic [WordW-1:0]    rd1_reg, rd2_reg;
    logic                rd1_ok_reg, rd2_ok_reg;

    // execute stage
    logic                ex_valid_reg;
    logic [WordW-1:0]    ex_ins_reg;

    // last write, for forwarding
    logic                lw_valid_reg;
    logic [RegAddrW-1:0] lw_addr_reg;
    logic [WordW-1:0]    lw_data_reg;

    // architectural state
    logic [WordW-1:0]    pc_reg, pc_next;
    logic [FlagW-1:0]    flag_reg, flag_next;

    // output register
    logic                m_valid_reg;
    logic                m_pvalid_reg;
    logic [WordW-1:0]    m_pval_reg, m_pc_reg;
    logic [FlagW-1:0]    m_flag_reg;

    logic                s_accept;
    logic                ex_adv;
    opcode_t             ex_op;
    logic [RegAddrW-1:0] ex_dst, ex_s1, ex_s2;
    logic [WordW-1:0]    op1, op2;
    logic                wr_en;
    logic [WordW-1:0]    wr_data;
    logic                pvalid;
    logic [WordW-1:0]    pval;

    assign ex_adv   = ex_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !ex_valid_reg || ex_adv;
    assign s_accept = s_tvalid && s_tready;

    assign ex_op  = opcode_t'(ex_ins_reg[WordW-1 -: OpW]);
    assign ex_dst = ex_ins_reg[11:9];
    assign ex_s1  = ex_ins_reg[8:6];
    assign ex_s2  = ex_ins_reg[2:0];

    // operands: forward the last write, else the registered read (zero if never written)
    always_comb begin
        if (lw_valid_reg && (lw_addr_reg == ex_s1)) begin
            op1 = lw_data_reg;
        end else begin
            op1 = rd1_ok_reg ? rd1_reg : '0;
        end
        if (lw_valid_reg && (lw_addr_reg == ex_s2)) begin
            op2 = lw_data_reg;
        end else begin
            op2 = rd2_ok_reg ? rd2_reg : '0;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_data = '0;
        pvalid  = 1'b0;
        pval    = '0;
        pc_next = pc_reg;
        case (ex_op)
            OP_ADD: begin
                wr_en   = 1'b1;
                wr_data = op1 + op2;
            end
            OP_LD: begin
                wr_en   = 1'b1;
                wr_data = {{(WordW-ImmW){ex_ins_reg[ImmW-1]}}, ex_ins_reg[ImmW-1:0]};
            end
            OP_AND: begin
                wr_en   = 1'b1;
                wr_data = op1 & op2;
            end
            OP_NOT: begin
                wr_en   = 1'b1;
                wr_data = ~op1;
            end
            OP_JMP: begin
                pc_next = op1;
            end
            OP_SHOW: begin
                pvalid = 1'b1;
                pval   = op2;
            end
            default: begin
            end
        endcase
        flag_next = wr_en ? flags_of(wr_data) : flag_reg;
    end

    // memory: registered reads at accept, write back when the execute stage advances
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd1_reg <= rf_mem[s_tdata[8:6]];
            rd2_reg <= rf_mem[s_tdata[2:0]];
        end
        if (ex_adv && wr_en) begin
            rf_mem[ex_dst] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
            rd1_ok_reg   <= 1'b0;
            rd2_ok_reg   <= 1'b0;
            ex_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            pc_reg       <= PC_RESET;
            flag_reg     <= FLAG_ZERO;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                rd1_ok_reg <= rf_valid_reg[s_tdata[8:6]];
                rd2_ok_reg <= rf_valid_reg[s_tdata[2:0]];
            end
            if (s_accept) begin
                ex_valid_reg <= 1'b1;
            end else if (ex_adv) begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_adv) begin
                pc_reg   <= pc_next;
                flag_reg <= flag_next;
                if (wr_en) begin
                    rf_valid_reg[ex_dst] <= 1'b1;
                    lw_valid_reg         <= 1'b1;
                end
            end
            if (ex_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ex_ins_reg <= s_tdata;
        end
        if (ex_adv && wr_en) begin
            lw_addr_reg <= ex_dst;
            lw_data_reg <= wr_data;
        end
        if (ex_adv) begin
            m_pvalid_reg <= pvalid;
            m_pval_reg   <= pval;
            m_pc_reg     <= pc_next;
            m_flag_reg   <= flag_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_pvalid_reg;
    assign m_tdata  = {{(MDataW-2*WordW-FlagW){1'b0}}, m_flag_reg, m_pc_reg, m_pval_reg};

`ifndef SYNTHESIS
    a_flags_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(flag_reg))
        else $error("flag register not one-hot");

    a_pc_only_jmp: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ex_adv && (ex_op == OP_JMP)) |=> $stable(pc_reg))
        else $error("pc changed without a jump");

    a_print_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_pvalid_reg) |-> (m_pval_reg == '0))
        else $error("print value nonzero on non-print word");

    a_stall_holds_ex: assert property (@(posedge aclk) disable iff (!aresetn)
        (ex_valid_reg && !ex_adv) |=> (ex_valid_reg && $stable(ex_ins_reg)))
        else $error("execute stage lost a stalled instruction");

    a_adv_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ex_adv |=> m_valid_reg)
        else $error("executed instruction produced no output word");
`endif

endmodule

[bench/tb_tiny_register_alu_machine.sv]
// Self-checking bench for tiny_register_alu_machine: directed and random instruction words,
// predicted results checked word by word on the m_ stream under random idling on both sides.
// Depends on trm_pkg and the tiny_register_alu_machine RTL.
`timescale 1ns / 100ps

module tb_tiny_register_alu_machine;
    import trm_pkg::*;

    typedef struct packed {
        logic             print_valid;
        logic [WordW-1:0] print_value;
        logic [WordW-1:0] pc;
        logic [FlagW-1:0] flags;
    } retire_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [WordW-1:0]     s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [MDataW-1:0]    m_tdata;   // [15:0] print_value, [31:16] program_counter,
                                     // [34:32] condition_flags, [39:35] zero
    logic                 m_tuser;   // [0] print_valid

    // architectural state as the bench sees it
    logic [WordW-1:0]     gpr [RegCount];
    logic [WordW-1:0]     pc_q;
    logic [FlagW-1:0]     flags_q;

    logic [WordW-1:0]     program_q [$];
    retire_t              retire_q [$];
    retire_t              want;
    int                   errors    = 0;
    int                   in_gap    = 0;
    int                   stall_left = 0;
    int                   idle_len  = 0;
    int                   mode_left = 0;
    logic                 quiet     = 1'b0;

    tiny_register_alu_machine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    function automatic logic [FlagW-1:0] sign_class(input logic [WordW-1:0] v);
        logic [FlagW-1:0] f;
        if (v == '0) begin
            f = FLAG_ZERO;
        end else if (v[WordW-1]) begin
            f = FLAG_NEG;
        end else begin
            f = FLAG_POS;
        end
        return f;
    endfunction

    function automatic logic [WordW-1:0] op_rr(input opcode_t op, input int d, input int a,
                                               input int b);
        return {op, d[2:0], a[2:0], 3'b000, b[2:0]};
    endfunction

    function automatic logic [WordW-1:0] op_ld(input int d, input int imm);
        return {OP_LD, d[2:0], imm[8:0]};
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (quiet) return 0;
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Execute one instruction on the bench state and queue the retire record it yields.
    task automatic execute_instr(input logic [WordW-1:0] w);
        retire_t          r;
        logic [WordW-1:0] res;
        logic             wr;
        r   = '0;
        res = '0;
        wr  = 1'b0;
        case (w[15:12])
            OP_ADD: begin
                res = gpr[w[8:6]] + gpr[w[2:0]];
                wr  = 1'b1;
            end
            OP_LD: begin
                res = {{(WordW-ImmW){w[ImmW-1]}}, w[ImmW-1:0]};
                wr  = 1'b1;
            end
            OP_AND: begin
                res = gpr[w[8:6]] & gpr[w[2:0]];
                wr  = 1'b1;
            end
            OP_NOT: begin
                res = ~gpr[w[8:6]];
                wr  = 1'b1;
            end
            OP_JMP: begin
                pc_q = gpr[w[8:6]];
            end
            OP_SHOW: begin
                r.print_valid = 1'b1;
                r.print_value = gpr[w[2:0]];
            end
            default: ;
        endcase
        if (wr) begin
            gpr[w[11:9]] = res;
            flags_q      = sign_class(res);
        end
        r.pc    = pc_q;
        r.flags = flags_q;
        retire_q.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [WordW-1:0] exp_v,
                               input logic [WordW-1:0] got_v);
        if (exp_v !== got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
        end
    endtask

    // alternate stretches with and without idling
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            quiet     <= ($urandom_range(0, 3) == 0);
            mode_left <= $urandom_range(40, 250);
        end else begin
            mode_left <= mode_left - 1;
        end
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            in_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                execute_instr(s_tdata);
            end
            if (s_tvalid && !s_tready) begin
                // hold the word until taken
            end else if (in_gap > 0) begin
                in_gap   <= in_gap - 1;
                s_tvalid <= 1'b0;
            end else if (program_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= program_q.pop_front();
                in_gap   <= pick_idle();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (retire_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual tdata %h tuser %b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = retire_q.pop_front();
                    check_field("print_valid", WordW'(want.print_valid), WordW'(m_tuser));
                    check_field("print_value", want.print_value, m_tdata[15:0]);
                    check_field("program_counter", want.pc, m_tdata[31:16]);
                    check_field("condition_flags", WordW'(want.flags), WordW'(m_tdata[34:32]));
                    check_field("tdata padding", '0, WordW'(m_tdata[39:35]));
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else begin
                idle_len = pick_idle();
                if (idle_len > 0) begin
                    m_tready   <= 1'b0;
                    stall_left <= idle_len - 1;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        logic [WordW-1:0] w;
        int               op;
        for (int i = 0; i < RegCount; i++) gpr[i] = '0;
        pc_q    = PC_RESET;
        flags_q = FLAG_ZERO;

        // immediates: largest positive, most negative, zero, minus one, one
        program_q.push_back(op_ld(0, 'h0FF));
        program_q.push_back(op_ld(1, 'h100));
        program_q.push_back(op_ld(2, 'h000));
        program_q.push_back(op_ld(3, 'h1FF));
        program_q.push_back(op_ld(7, 'h001));
        // add: negative, wrap to zero, wrap to positive
        program_q.push_back(op_rr(OP_ADD, 4, 3, 3));
        program_q.push_back(op_rr(OP_ADD, 6, 3, 7));
        program_q.push_back(op_rr(OP_ADD, 5, 0, 3));
        program_q.push_back(op_rr(OP_AND, 5, 1, 3));
        program_q.push_back(op_rr(OP_AND, 6, 0, 1));
        program_q.push_back(op_rr(OP_NOT, 6, 2, 0));
        program_q.push_back(op_rr(OP_NOT, 5, 6, 0));
        program_q.push_back(op_rr(OP_NOT, 4, 1, 0));
        program_q.push_back(op_rr(OP_JMP, 0, 1, 0));
        program_q.push_back(op_rr(OP_JMP, 0, 2, 0));
        program_q.push_back(op_rr(OP_SHOW, 0, 0, 3));
        program_q.push_back(op_rr(OP_SHOW, 0, 0, 2));
        // no-op and unused opcodes leave everything alone
        program_q.push_back(16'h0000);
        program_q.push_back(16'h0FFF);
        program_q.push_back(16'h7ABC);
        program_q.push_back(16'hFFFF);
        // ignored bits set
        program_q.push_back(op_rr(OP_ADD, 0, 0, 7) | 16'h0038);
        program_q.push_back({OP_JMP, 3'b111, 3'd6, 6'h3F});
        program_q.push_back({OP_SHOW, 9'h1FF, 3'd0});

        // mostly well-formed instructions with random fields, some raw noise
        repeat (550) begin
            w = WordW'($urandom);
            if ($urandom_range(0, 99) < 85) begin
                op = $urandom_range(1, 6);
                w[15:12] = op[3:0];
            end
            program_q.push_back(w);
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (program_q.size() != 0 || s_tvalid || retire_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #500000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
